// ===== hw/rtl/spsp_pkg.sv =====
// shared constants and types for the serpentine panorama shot planner
package spsp_pkg;

    localparam int IDX_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int OVL_W = 7;
    localparam int VIEW_W = 23;
    localparam int POS_W = 24;
    localparam int TGT_W = 32;
    localparam int GRID_OUT_W = 8;
    localparam int STATUS_W = 2;
    localparam int PDIV_W = 32;
    localparam int PCNT_W = 5;
    localparam int STEP_W = POS_W + 1;
    localparam int DIV_STAGES = 4;
    localparam int DIV_BITS = IDX_W / DIV_STAGES;

    // floor(x / 100) as (x * RECIP_100) >> RECIP_SH, exact for x below 2**30
    localparam int RECIP_W = 31;
    localparam int RECIP_SH = 37;
    localparam int PROD_W = PDIV_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_100 = 31'd1374389535;

    localparam int DEF_MAX_SHOTS_PER_AXIS = 255;
    localparam int DEF_NARROW_TILT_STEPS = 444;

    localparam logic [OVL_W-1:0] OVL_RESET = 7'd20;
    localparam logic [OVL_W-1:0] PERCENT = 7'd100;

    localparam logic [CFG_IDX_W-1:0] REG_OVERLAP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_VIEW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_VIEW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BEYOND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_STEP = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd3;

    typedef enum logic [3:0] {
        PS_IDLE = 4'b0001,
        PS_LOAD = 4'b0010,
        PS_DIV  = 4'b0100,
        PS_DONE = 4'b1000
    } plan_state_t;

    typedef enum logic [2:0] {
        OP_MAX_X  = 3'd0,
        OP_MAX_Y  = 3'd1,
        OP_COLS   = 3'd2,
        OP_ROWS   = 3'd3,
        OP_STEP_X = 3'd4,
        OP_STEP_Y = 3'd5
    } plan_op_t;

endpackage

// ===== hw/rtl/serpentine_pano_shot_planner.sv =====
// top level of the serpentine panorama shot planner
//
// configuration: cfg_valid/cfg_ready write cfg_data into register cfg_index
// (0 overlap, 1 pan view, 2 tilt view, 3 span x, 4 span y, 5 start x,
// 6 start y); cfg_ready is always high
// after reset and after every configuration write a planner recomputes the
// grid: two reciprocal multiplications and four divisions on one shared
// bit-serial divider, during which in_stall is high
// input: in_valid/in_stall with shot_index; output: out_valid/out_stall with
// target_x, target_y, column, row, total_shots, last_shot and status
// each shot index runs through an 8-stage pipeline: clamp, four radix-16
// stages of index / columns, serpentine fold, multiply, subtract
// out_valid rises when a taken transfer reaches the subtract stage; one
// transfer per cycle when the receiver keeps out_stall low and the planner is idle
// a high out_stall on a valid result holds the whole pipeline and raises
// in_stall, nothing is dropped or repeated
// reset clears all valid bits, loads register defaults and starts planning
module serpentine_pano_shot_planner #(
    parameter int MAX_SHOTS_PER_AXIS = spsp_pkg::DEF_MAX_SHOTS_PER_AXIS,
    parameter int NARROW_TILT_STEPS = spsp_pkg::DEF_NARROW_TILT_STEPS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [spsp_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [spsp_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [spsp_pkg::IDX_W-1:0]              shot_index,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [spsp_pkg::TGT_W-1:0]       target_x,
    output logic signed [spsp_pkg::TGT_W-1:0]       target_y,
    output logic [spsp_pkg::GRID_OUT_W-1:0]         column,
    output logic [spsp_pkg::GRID_OUT_W-1:0]         row,
    output logic [spsp_pkg::IDX_W-1:0]              total_shots,
    output logic                                    last_shot,
    output logic [spsp_pkg::STATUS_W-1:0]           status
);
    import spsp_pkg::*;

    localparam int CW = $clog2(MAX_SHOTS_PER_AXIS + 1);
    localparam int TW = 2 * CW;
    localparam int XW = ((TW > IDX_W) ? TW : IDX_W) + 1;
    localparam int PW = STEP_W + CW + 1;
    localparam int NST = DIV_STAGES + 4;
    localparam int OUT_ST = NST - 1;

    // configuration registers
    logic [OVL_W-1:0]         overlap_reg;
    logic [VIEW_W-1:0]        pan_view_reg;
    logic [VIEW_W-1:0]        tilt_view_reg;
    logic signed [POS_W-1:0]  span_x_reg;
    logic signed [POS_W-1:0]  span_y_reg;
    logic signed [POS_W-1:0]  start_x_reg;
    logic signed [POS_W-1:0]  start_y_reg;
    logic                     cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlap_reg <= OVL_RESET;
            pan_view_reg <= '0;
            tilt_view_reg <= '0;
            span_x_reg <= '0;
            span_y_reg <= '0;
            start_x_reg <= '0;
            start_y_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_OVERLAP:   overlap_reg <= cfg_data[OVL_W-1:0];
                REG_PAN_VIEW:  pan_view_reg <= cfg_data[VIEW_W-1:0];
                REG_TILT_VIEW: tilt_view_reg <= cfg_data[VIEW_W-1:0];
                REG_SPAN_X:    span_x_reg <= cfg_data[POS_W-1:0];
                REG_SPAN_Y:    span_y_reg <= cfg_data[POS_W-1:0];
                REG_START_X:   start_x_reg <= cfg_data[POS_W-1:0];
                REG_START_Y:   start_y_reg <= cfg_data[POS_W-1:0];
                default:       ;
            endcase
        end
    end

    // grid planner
    plan_state_t              state_reg;
    plan_op_t                 op_reg;
    logic [PCNT_W-1:0]        cnt_reg;
    logic [PDIV_W-1:0]        num_reg;
    logic [PDIV_W-1:0]        den_reg;
    logic [PDIV_W:0]          rem_reg;
    logic                     skip_reg;
    logic [PDIV_W-1:0]        msx_reg;
    logic [PDIV_W-1:0]        msy_reg;
    logic [CW-1:0]            cols_reg;
    logic [CW-1:0]            rows_reg;
    logic signed [STEP_W-1:0] stepx_reg;
    logic signed [STEP_W-1:0] stepy_reg;
    logic [TW-1:0]            total_reg;
    logic                     zero_reg;
    logic                     sat_reg;
    logic                     busy;

    logic [POS_W-1:0]         magx;
    logic [POS_W-1:0]         magy;
    logic                     narrow;
    logic [OVL_W-1:0]         factor;
    logic [PDIV_W:0]          rem_shift;
    logic [PDIV_W:0]          rem_sub;
    logic [PDIV_W:0]          shots;
    logic                     shots_sat;
    logic [STEP_W-1:0]        qstep;
    logic [PROD_W-1:0]        ms_prod;

    assign magx = span_x_reg[POS_W-1] ? (~span_x_reg + 1'b1) : span_x_reg;
    assign magy = span_y_reg[POS_W-1] ? (~span_y_reg + 1'b1) : span_y_reg;
    assign narrow = 32'(magy) < 32'(NARROW_TILT_STEPS);
    assign factor = (overlap_reg >= PERCENT) ? '0 : (PERCENT - overlap_reg);
    assign rem_shift = {rem_reg[PDIV_W-1:0], num_reg[PDIV_W-1]};
    assign rem_sub = rem_shift - {1'b0, den_reg};
    assign shots = (PDIV_W + 1)'(num_reg) + (PDIV_W + 1)'(2);
    assign shots_sat = shots > (PDIV_W + 1)'(MAX_SHOTS_PER_AXIS);
    assign qstep = skip_reg ? '0 : num_reg[STEP_W-1:0];
    assign ms_prod = num_reg * RECIP_100;
    assign busy = state_reg != PS_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PS_LOAD;
            op_reg <= OP_MAX_X;
            cnt_reg <= '0;
        end
        else if (cfg_wr)
        begin
            state_reg <= PS_LOAD;
            op_reg <= OP_MAX_X;
        end
        else
        begin
            unique case (state_reg)
                PS_IDLE: ;
                PS_LOAD:
                begin
                    cnt_reg <= '1;
                    if (op_reg == OP_MAX_X || op_reg == OP_MAX_Y)
                    begin
                        state_reg <= PS_DONE;
                    end
                    else
                    begin
                        state_reg <= PS_DIV;
                    end
                end
                PS_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= PS_DONE;
                    end
                end
                PS_DONE:
                begin
                    if (op_reg == OP_STEP_Y)
                    begin
                        state_reg <= PS_IDLE;
                    end
                    else
                    begin
                        op_reg <= plan_op_t'(op_reg + 3'd1);
                        state_reg <= PS_LOAD;
                    end
                end
                default: state_reg <= PS_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            PS_LOAD:
            begin
                rem_reg <= '0;
                unique case (op_reg)
                    OP_MAX_X:
                    begin
                        zero_reg <= 1'b0;
                        sat_reg <= 1'b0;
                        num_reg <= PDIV_W'(pan_view_reg * factor);
                    end
                    OP_MAX_Y:
                    begin
                        num_reg <= PDIV_W'(tilt_view_reg * factor);
                    end
                    OP_COLS:
                    begin
                        num_reg <= PDIV_W'(magx);
                        den_reg <= msx_reg;
                        skip_reg <= msx_reg == '0;
                    end
                    OP_ROWS:
                    begin
                        num_reg <= PDIV_W'(magy);
                        den_reg <= msy_reg;
                        skip_reg <= narrow || (msy_reg == '0);
                    end
                    OP_STEP_X:
                    begin
                        num_reg <= PDIV_W'(magx);
                        den_reg <= PDIV_W'(cols_reg - 1'b1);
                        skip_reg <= cols_reg == CW'(1);
                    end
                    OP_STEP_Y:
                    begin
                        num_reg <= PDIV_W'(magy);
                        den_reg <= PDIV_W'(rows_reg - 1'b1);
                        skip_reg <= rows_reg == CW'(1);
                    end
                    default: ;
                endcase
            end
            PS_DIV:
            begin
                if (!rem_sub[PDIV_W])
                begin
                    rem_reg <= rem_sub;
                    num_reg <= {num_reg[PDIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_shift;
                    num_reg <= {num_reg[PDIV_W-2:0], 1'b0};
                end
            end
            PS_DONE:
            begin
                unique case (op_reg)
                    OP_MAX_X: msx_reg <= PDIV_W'(ms_prod[PROD_W-1:RECIP_SH]);
                    OP_MAX_Y: msy_reg <= PDIV_W'(ms_prod[PROD_W-1:RECIP_SH]);
                    OP_COLS:
                    begin
                        if (skip_reg)
                        begin
                            cols_reg <= CW'(1);
                            zero_reg <= 1'b1;
                        end
                        else if (shots_sat)
                        begin
                            cols_reg <= CW'(MAX_SHOTS_PER_AXIS);
                            sat_reg <= 1'b1;
                        end
                        else
                        begin
                            cols_reg <= shots[CW-1:0];
                        end
                    end
                    OP_ROWS:
                    begin
                        if (skip_reg)
                        begin
                            rows_reg <= CW'(1);
                            zero_reg <= zero_reg || !narrow;
                        end
                        else if (shots_sat)
                        begin
                            rows_reg <= CW'(MAX_SHOTS_PER_AXIS);
                            sat_reg <= 1'b1;
                        end
                        else
                        begin
                            rows_reg <= shots[CW-1:0];
                        end
                    end
                    OP_STEP_X:
                    begin
                        stepx_reg <= span_x_reg[POS_W-1] ? -$signed(qstep) : $signed(qstep);
                        total_reg <= TW'(cols_reg * rows_reg);
                    end
                    OP_STEP_Y:
                        stepy_reg <= span_y_reg[POS_W-1] ? -$signed(qstep) : $signed(qstep);
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // per-shot pipeline
    logic                     v_reg [0:NST-1];
    logic                     bey_reg [0:NST-2];
    logic                     last_reg [0:NST-2];
    logic [IDX_W-1:0]         dn_reg [0:DIV_STAGES];
    logic [CW-1:0]            dr_reg [0:DIV_STAGES];
    logic [IDX_W-1:0]         dn_next [1:DIV_STAGES];
    logic [CW-1:0]            dr_next [1:DIV_STAGES];
    logic [CW-1:0]            col_reg;
    logic [CW-1:0]            row_reg;
    logic [CW-1:0]            col6_reg;
    logic [CW-1:0]            row6_reg;
    logic signed [PW-1:0]     px_reg;
    logic signed [PW-1:0]     py_reg;
    logic signed [TGT_W-1:0]  tx_reg;
    logic signed [TGT_W-1:0]  ty_reg;
    logic [CW-1:0]            colo_reg;
    logic [CW-1:0]            rowo_reg;
    logic                     bey_o_reg;
    logic                     last_o_reg;
    logic                     en;
    logic                     acc;
    logic [XW-1:0]            idx_ext;
    logic                     beyond_in;
    logic [IDX_W-1:0]         idx_clamp;
    logic [CW-1:0]            m_fold;

    assign en = !(v_reg[OUT_ST] && out_stall);
    assign in_stall = busy || !en;
    assign acc = in_valid && !in_stall;
    assign idx_ext = XW'(shot_index);
    assign beyond_in = idx_ext >= XW'(total_reg);
    assign idx_clamp = beyond_in ? IDX_W'(total_reg - 1'b1) : shot_index;
    assign m_fold = dr_reg[DIV_STAGES];

    always_comb
    begin
        logic [IDX_W-1:0] n;
        logic [CW:0]      r;
        for (int k = 1; k <= DIV_STAGES; k++)
        begin
            n = dn_reg[k-1];
            r = {1'b0, dr_reg[k-1]};
            for (int b = 0; b < DIV_BITS; b++)
            begin
                r = {r[CW-1:0], n[IDX_W-1]};
                n = {n[IDX_W-2:0], 1'b0};
                if (r >= {1'b0, cols_reg})
                begin
                    r = r - {1'b0, cols_reg};
                    n[0] = 1'b1;
                end
            end
            dn_next[k] = n;
            dr_next[k] = r[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= acc;
            for (int k = 1; k < NST; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dn_reg[0] <= idx_clamp;
            dr_reg[0] <= '0;
            bey_reg[0] <= beyond_in;
            last_reg[0] <= !beyond_in && (idx_ext == XW'(total_reg) - 1'b1);
            for (int k = 1; k <= DIV_STAGES; k++)
            begin
                dn_reg[k] <= dn_next[k];
                dr_reg[k] <= dr_next[k];
            end
            for (int k = 1; k < NST - 1; k++)
            begin
                bey_reg[k] <= bey_reg[k-1];
                last_reg[k] <= last_reg[k-1];
            end
            row_reg <= dn_reg[DIV_STAGES][CW-1:0];
            col_reg <= dn_reg[DIV_STAGES][0] ? (cols_reg - 1'b1 - m_fold) : m_fold;
            px_reg <= stepx_reg * $signed({1'b0, col_reg});
            py_reg <= stepy_reg * $signed({1'b0, row_reg});
            col6_reg <= col_reg;
            row6_reg <= row_reg;
            tx_reg <= TGT_W'(start_x_reg) - TGT_W'(px_reg);
            ty_reg <= TGT_W'(start_y_reg) - TGT_W'(py_reg);
            colo_reg <= col6_reg;
            rowo_reg <= row6_reg;
            bey_o_reg <= bey_reg[NST-2];
            last_o_reg <= last_reg[NST-2];
        end
    end

    logic [IDX_W-1:0] col_wide;
    logic [IDX_W-1:0] row_wide;

    assign col_wide = IDX_W'(colo_reg);
    assign row_wide = IDX_W'(rowo_reg);
    assign out_valid = v_reg[OUT_ST];
    assign target_x = tx_reg;
    assign target_y = ty_reg;
    assign column = col_wide[GRID_OUT_W-1:0];
    assign row = row_wide[GRID_OUT_W-1:0];
    assign total_shots = IDX_W'(total_reg);
    assign last_shot = last_o_reg;
    assign status = zero_reg ? ST_ZERO_STEP :
                    sat_reg ? ST_SATURATED :
                    bey_o_reg ? ST_BEYOND : ST_OK;

`ifndef SYNTHESIS
    a_cfg_replans: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> busy)
        else $error("configuration write did not restart planning");
    a_row_in_plan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !busy |-> rowo_reg < rows_reg && colo_reg < cols_reg)
        else $error("row or column outside planned grid");
    a_beyond_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(bey_o_reg && last_o_reg))
        else $error("beyond-plan shot flagged as last");
    a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> total_reg != '0)
        else $error("planned grid is empty");
`endif

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the serpentine panorama shot planner
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import spsp_pkg::*;

    typedef struct packed {
        logic signed [TGT_W-1:0] tx;
        logic signed [TGT_W-1:0] ty;
        logic [GRID_OUT_W-1:0] col;
        logic [GRID_OUT_W-1:0] rw;
        logic [IDX_W-1:0] total;
        logic last;
        logic [STATUS_W-1:0] st;
    } shot_t;

    class shot_scoreboard;
        logic [OVL_W-1:0] overlap;
        logic [VIEW_W-1:0] pan_view, tilt_view;
        logic [POS_W-1:0] span_x, span_y, start_x, start_y;
        shot_t pending[$];
        int errors;

        function new();
            overlap = OVL_RESET;
            pan_view = '0;
            tilt_view = '0;
            span_x = '0;
            span_y = '0;
            start_x = '0;
            start_y = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_OVERLAP: overlap = d[OVL_W-1:0];
                REG_PAN_VIEW: pan_view = d[VIEW_W-1:0];
                REG_TILT_VIEW: tilt_view = d[VIEW_W-1:0];
                REG_SPAN_X: span_x = d;
                REG_SPAN_Y: span_y = d;
                REG_START_X: start_x = d;
                REG_START_Y: start_y = d;
                default: ;
            endcase
        endfunction

        function longint axis_shots(logic [VIEW_W-1:0] view, longint span, bit narrow,
                                    ref bit zero_f, ref bit sat_f);
            longint mag, ms;
            mag = span < 0 ? -span : span;
            if (narrow)
                return 1;
            ms = (overlap >= 100) ? 0 : (longint'(view) * (100 - overlap)) / 100;
            if (ms == 0)
            begin
                zero_f = 1;
                return 1;
            end
            if (mag / ms + 2 > DEF_MAX_SHOTS_PER_AXIS)
            begin
                sat_f = 1;
                return DEF_MAX_SHOTS_PER_AXIS;
            end
            return mag / ms + 2;
        endfunction

        function void note_index(logic [IDX_W-1:0] shot);
            bit zero_f, sat_f, beyond;
            longint sx, sy, cols, rows, stx, sty, total, idx, r, m, c;
            shot_t e;
            zero_f = 0;
            sat_f = 0;
            sx = longint'(signed'(span_x));
            sy = longint'(signed'(span_y));
            cols = axis_shots(pan_view, sx, 0, zero_f, sat_f);
            rows = axis_shots(tilt_view, sy, (sy < 0 ? -sy : sy) < DEF_NARROW_TILT_STEPS,
                              zero_f, sat_f);
            stx = cols > 1 ? sx / (cols - 1) : 0;
            sty = rows > 1 ? sy / (rows - 1) : 0;
            total = cols * rows;
            idx = shot;
            beyond = idx >= total;
            if (beyond)
                idx = total - 1;
            r = idx / cols;
            m = idx % cols;
            c = r[0] ? cols - 1 - m : m;
            e.tx = longint'(signed'(start_x)) - stx * c;
            e.ty = longint'(signed'(start_y)) - sty * r;
            e.col = c;
            e.rw = r;
            e.total = total;
            e.last = !beyond && idx == total - 1;
            e.st = zero_f ? ST_ZERO_STEP : sat_f ? ST_SATURATED : beyond ? ST_BEYOND : ST_OK;
            pending.push_back(e);
        endfunction

        function void check_shot(shot_t got);
            shot_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.tx !== e.tx)
            begin
                $error("target_x expected %0d actual %0d", e.tx, got.tx);
                errors++;
            end
            if (got.ty !== e.ty)
            begin
                $error("target_y expected %0d actual %0d", e.ty, got.ty);
                errors++;
            end
            if (got.col !== e.col)
            begin
                $error("column expected %0d actual %0d", e.col, got.col);
                errors++;
            end
            if (got.rw !== e.rw)
            begin
                $error("row expected %0d actual %0d", e.rw, got.rw);
                errors++;
            end
            if (got.total !== e.total)
            begin
                $error("total_shots expected %0d actual %0d", e.total, got.total);
                errors++;
            end
            if (got.last !== e.last)
            begin
                $error("last_shot expected %0d actual %0d", e.last, got.last);
                errors++;
            end
            if (got.st !== e.st)
            begin
                $error("status expected %0d actual %0d", e.st, got.st);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_stall;
    logic [IDX_W-1:0] shot_index = '0;
    logic out_valid;
    logic out_stall = 0;
    logic signed [TGT_W-1:0] target_x, target_y;
    logic [GRID_OUT_W-1:0] column, row;
    logic [IDX_W-1:0] total_shots;
    logic last_shot;
    logic [STATUS_W-1:0] status;

    shot_scoreboard plan_sb = new();
    bit draining = 0;
    int stall_left = 0;

    serpentine_pano_shot_planner dut (.*);

    always #5 clk = ~clk;

    function automatic int pick_gap();
        if ($urandom_range(0, 2) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    task automatic send_shot(logic [IDX_W-1:0] idx);
        int gap;
        gap = draining ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        shot_index <= idx;
        do @(posedge clk); while (in_stall);
        plan_sb.note_index(idx);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        plan_sb.write_reg(idx, d);
    endtask

    task automatic wait_idle();
        in_valid <= 0;
        while (plan_sb.pending.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic load_plan(int ovl, int pv, int tv, int sx, int sy, int x0, int y0);
        wait_idle();
        write_cfg(REG_OVERLAP, CFG_DATA_W'(ovl));
        write_cfg(REG_PAN_VIEW, CFG_DATA_W'(pv));
        write_cfg(REG_TILT_VIEW, CFG_DATA_W'(tv));
        write_cfg(REG_SPAN_X, CFG_DATA_W'(sx));
        write_cfg(REG_SPAN_Y, CFG_DATA_W'(sy));
        write_cfg(REG_START_X, CFG_DATA_W'(x0));
        write_cfg(REG_START_Y, CFG_DATA_W'(y0));
        cfg_valid <= 0;
    endtask

    function automatic logic [IDX_W-1:0] rand_shot();
        case ($urandom_range(0, 9))
            0: return IDX_W'($urandom());
            1: return 16'hFFFF;
            default: return IDX_W'($urandom_range(0, 300));
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            plan_sb.check_shot('{target_x, target_y, column, row, total_shots,
                                 last_shot, status});
        if (stall_left > 0)
        begin
            out_stall <= 1;
            stall_left = stall_left - 1;
        end
        else
        begin
            out_stall <= 0;
            stall_left = pick_gap();
        end
    end

    initial
    begin
        int v;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        send_shot(0);
        send_shot(16'hFFFF);
        load_plan(20, 1000, 800, 5000, 2000, 100, -50);
        for (int i = 0; i < 8; i++) send_shot(i);
        send_shot(16'hFFFF);
        load_plan(99, 8388607, 8388607, -8388608, 8388607, 8388607, -8388608);
        send_shot(0);
        send_shot(3);
        send_shot(4);
        load_plan(100, 500, 500, 8388607, -8388608, -8388608, 8388607);
        send_shot(0);
        send_shot(1);
        load_plan(1, 1, 1, 8388607, 443, 0, 0);
        send_shot(254);
        send_shot(255);
        send_shot(16'hAAAA);
        load_plan(127, 0, 100, 10, -444, 5, 5);
        send_shot(0);
        send_shot(16'h5555);
        for (int p = 0; p < 18; p++)
        begin
            load_plan($urandom_range(1, 99),
                      $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(50, 5000),
                      $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(50, 5000),
                      $urandom_range(0, 1) ? $urandom()
                                           : int'($urandom_range(0, 40000)) - 20000,
                      $urandom_range(0, 1) ? $urandom()
                                           : int'($urandom_range(0, 20000)) - 10000,
                      $urandom(), $urandom());
            for (int i = 0; i < 50; i++)
            begin
                v = $urandom_range(0, 2);
                send_shot(v == 0 ? i[IDX_W-1:0] : rand_shot());
            end
        end
        draining = 1;
        wait_idle();
        repeat (20) @(posedge clk);
        if (plan_sb.errors == 0 && plan_sb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
